// File: rtl/crc16bc_pkg.sv
// Shared types, constants and the CRC byte update for the CRC-16 block checker.
package crc16bc_pkg;

    localparam logic [15:0] CRC_POLY          = 16'h8005;
    localparam int          MIN_BLOCK_LEN_DEF = 4;
    localparam logic [7:0]  COUNT_MAX         = 8'hFF;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_COUNT_BAD = 3'd1,
        STATUS_TOO_SHORT = 3'd2,
        STATUS_TOTAL_BAD = 3'd3,
        STATUS_CRC_BAD   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] expected_length;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] computed_crc;
        logic [7:0]  count_field;
    } out_item_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        logic        top;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            top = crc[15];
            crc = {crc[14:0], 1'b0};
            if (b[i] != top)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/crc16bc_if.sv
// Valid/ready channel interfaces for received bytes and block results.
interface crc16bc_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] expected_length;
    logic       last_byte;

    modport source (output valid, output data_byte, output expected_length,
                    output last_byte, input ready);
    modport sink (input valid, input data_byte, input expected_length,
                  input last_byte, output ready);
endinterface

interface crc16bc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] computed_crc;
    logic [7:0]  count_field;

    modport source (output valid, output status, output computed_crc,
                    output count_field, input ready);
    modport sink (input valid, input status, input computed_crc,
                  input count_field, output ready);
endinterface

// File: rtl/crc16_block_checker.sv
// Top level: streaming CRC-16 check of one response block, one byte per transaction.
// A last byte passes the input register and then the result register to its result.
// Throughput: one byte per cycle unless a waiting result holds a last byte.
// A waiting result stalls a last-byte transaction and the bytes behind it; earlier bytes keep flowing.
// Reset (rst_n low, asynchronous) clears the block state and both valid flags.
module crc16_block_checker #(
    parameter int MIN_BLOCK_LEN = crc16bc_pkg::MIN_BLOCK_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    crc16bc_data_if.sink      data_ch,
    crc16bc_result_if.source  result_ch
);
    import crc16bc_pkg::*;

    logic     item_valid;
    logic     advance;
    in_item_t item;

    crc16bc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_ch    (data_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    crc16bc_core #(
        .MIN_BLOCK_LEN (MIN_BLOCK_LEN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .result_ch  (result_ch)
    );
endmodule

// File: rtl/crc16bc_in_stage.sv
// Input register stage: captures one received byte transaction per cycle while the core advances.
module crc16bc_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    crc16bc_data_if.sink          data_ch,
    input  logic                  advance,
    output logic                  item_valid,
    output crc16bc_pkg::in_item_t item
);
    import crc16bc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign data_ch.ready = !valid_reg || advance;
    assign take          = data_ch.valid && data_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{data_byte:       data_ch.data_byte,
                          expected_length: data_ch.expected_length,
                          last_byte:       data_ch.last_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// File: rtl/crc16bc_core.sv
// Block state, CRC update, status decision and result register.
module crc16bc_core #(
    parameter int MIN_BLOCK_LEN = crc16bc_pkg::MIN_BLOCK_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  crc16bc_pkg::in_item_t item,
    output logic                  advance,
    crc16bc_result_if.source      result_ch
);
    import crc16bc_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [15:0] tail_reg, tail_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  want_reg, want_next;
    logic        res_valid_reg, res_valid_next;
    out_item_t   res_reg;
    out_item_t   res_new;
    logic        out_free;
    logic        is_first;

    assign out_free = !res_valid_reg || result_ch.ready;
    assign advance  = item_valid && (!item.last_byte || out_free);
    assign is_first = (seen_reg == 8'd0);

    always_comb
    begin
        first_next = is_first ? item.data_byte : first_reg;
        want_next  = is_first ? item.expected_length : want_reg;
        crc_next   = (seen_reg >= 8'd2) ? crc_feed(crc_reg, tail_reg[15:8]) : crc_reg;
        tail_next  = {tail_reg[7:0], item.data_byte};
        seen_next  = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + 8'd1;
    end

    always_comb
    begin
        res_new.computed_crc = crc_next;
        res_new.count_field  = first_next;
        priority if (want_next != first_next)
        begin
            res_new.status = STATUS_COUNT_BAD;
        end
        else if (want_next < 8'(MIN_BLOCK_LEN))
        begin
            res_new.status = STATUS_TOO_SHORT;
        end
        else if (seen_next != want_next)
        begin
            res_new.status = STATUS_TOTAL_BAD;
        end
        else if (crc_next[7:0] != tail_next[15:8] || crc_next[15:8] != tail_next[7:0])
        begin
            res_new.status = STATUS_CRC_BAD;
        end
        else
        begin
            res_new.status = STATUS_OK;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance && item.last_byte)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            tail_reg      <= '0;
            seen_reg      <= '0;
            first_reg     <= '0;
            want_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                if (item.last_byte)
                begin
                    crc_reg   <= '0;
                    tail_reg  <= '0;
                    seen_reg  <= '0;
                    first_reg <= '0;
                    want_reg  <= '0;
                end
                else
                begin
                    crc_reg   <= crc_next;
                    tail_reg  <= tail_next;
                    seen_reg  <= seen_next;
                    first_reg <= first_next;
                    want_reg  <= want_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.last_byte)
        begin
            res_reg <= res_new;
        end
    end

    assign result_ch.valid        = res_valid_reg;
    assign result_ch.status       = res_reg.status;
    assign result_ch.computed_crc = res_reg.computed_crc;
    assign result_ch.count_field  = res_reg.count_field;
endmodule

// File: rtl/crc16bc_checker.sv
// Port-level assertions for the CRC-16 block checker, bound to the top level.
module crc16bc_checker #(
    parameter int MIN_BLOCK_LEN = crc16bc_pkg::MIN_BLOCK_LEN_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        data_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  status,
    input logic [15:0] computed_crc,
    input logic [7:0]  count_field
);
    import crc16bc_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(computed_crc) && $stable(count_field))
        else $error("result transaction dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> data_ready)
        else $error("input stalled while no result is pending");

    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == STATUS_TOO_SHORT |-> count_field < 8'(MIN_BLOCK_LEN))
        else $error("too-short status with a count field at or above minimum");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == STATUS_OK |-> count_field >= 8'(MIN_BLOCK_LEN))
        else $error("ok status with a count field below minimum");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");
endmodule

bind crc16_block_checker crc16bc_checker #(
    .MIN_BLOCK_LEN (MIN_BLOCK_LEN)
) u_crc16bc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_ready   (data_ch.ready),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .status       (result_ch.status),
    .computed_crc (result_ch.computed_crc),
    .count_field  (result_ch.count_field)
);

// File: dv/crc16_block_checker_tb.sv
// Self-checking testbench for the CRC-16 block checker: directed and random blocks.
module crc16_block_checker_tb;
    import crc16bc_pkg::*;

    localparam int RANDOM_BYTES = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        logic [7:0]  count;
        logic [7:0]  want;
        int          nbytes;
        logic [7:0]  fill;
        bit          add_crc;
        logic [15:0] crc_flip;
        bit          typed;
        out_item_t   result;
    } block_row_t;

    typedef struct {
        bit        typed;
        out_item_t result;
    } typed_result_t;

    logic clk = 1'b0;
    logic rst_n;

    crc16bc_data_if   data_ch ();
    crc16bc_result_if result_ch ();

    crc16_block_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .result_ch (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // count, want, bytes, fill, add crc, crc flip, typed, typed result
    block_row_t dir_blocks [8] = '{
        '{8'h00, 8'h00, 1, 8'h00, 1'b0, 16'h0000, 1'b1, '{STATUS_TOO_SHORT, 16'h0000, 8'h00}},
        '{8'hFF, 8'hFF, 1, 8'h00, 1'b0, 16'h0000, 1'b1, '{STATUS_TOTAL_BAD, 16'h0000, 8'hFF}},
        '{8'h05, 8'h04, 2, 8'h5A, 1'b0, 16'h0000, 1'b1, '{STATUS_COUNT_BAD, 16'h0000, 8'h05}},
        '{8'h04, 8'h04, 4, 8'hFF, 1'b1, 16'h0000, 1'b0, '{STATUS_OK, 16'h0000, 8'h00}},
        '{8'h04, 8'h04, 4, 8'h00, 1'b1, 16'h0001, 1'b0, '{STATUS_OK, 16'h0000, 8'h00}},
        '{8'h04, 8'h04, 4, 8'hA5, 1'b1, 16'h8000, 1'b0, '{STATUS_OK, 16'h0000, 8'h00}},
        '{8'h03, 8'h03, 3, 8'h3C, 1'b1, 16'h0000, 1'b0, '{STATUS_OK, 16'h0000, 8'h00}},
        '{8'h04, 8'h04, 5, 8'hC3, 1'b1, 16'h0000, 1'b0, '{STATUS_OK, 16'h0000, 8'h00}}
    };

    // predictor state
    logic [15:0] blk_crc;
    logic [15:0] blk_tail;
    logic [7:0]  blk_seen;
    logic [7:0]  blk_count;
    logic [7:0]  blk_want;

    out_item_t     pending_results [$];
    typed_result_t typed_results [$];
    logic [7:0]    block_bytes [$];

    int mismatches;
    int results_checked;
    int items_sent;
    int blocks_sent;
    int overlong_blocks;
    int status_hits [5];
    int cycle_count;
    int burst_left;
    int stall_left;
    int mode_left;
    bit stall_mode;

    in_item_t      mon_item;
    out_item_t     mon_pred;
    out_item_t     mon_want;
    bit            mon_done;
    typed_result_t mon_typed;

    function automatic logic [15:0] crc16_lsb_in(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb = b[k] ^ c[15];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic clear_block_state();
        blk_crc   = '0;
        blk_tail  = '0;
        blk_seen  = '0;
        blk_count = '0;
        blk_want  = '0;
    endtask

    task automatic absorb_byte(input in_item_t it, output bit done, output out_item_t r);
        status_t st;
        if (blk_seen == 0)
        begin
            blk_count = it.data_byte;
            blk_want  = it.expected_length;
        end
        if (blk_seen >= 2)
            blk_crc = crc16_lsb_in(blk_crc, blk_tail[15:8]);
        blk_tail = {blk_tail[7:0], it.data_byte};
        if (blk_seen != COUNT_MAX)
            blk_seen++;
        done = it.last_byte;
        if (blk_want != blk_count)
            st = STATUS_COUNT_BAD;
        else if (blk_want < MIN_BLOCK_LEN_DEF)
            st = STATUS_TOO_SHORT;
        else if (blk_seen != blk_want)
            st = STATUS_TOTAL_BAD;
        else if (blk_crc[7:0] != blk_tail[15:8] || blk_crc[15:8] != blk_tail[7:0])
            st = STATUS_CRC_BAD;
        else
            st = STATUS_OK;
        r = '{st, blk_crc, blk_count};
        if (done)
            clear_block_state();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result();
        out_item_t e;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, status", result_ch.status, 0);
            return;
        end
        e = pending_results.pop_front();
        results_checked++;
        status_hits[e.status]++;
        if (result_ch.status != e.status)
            report_mismatch("status", result_ch.status, e.status);
        if (result_ch.computed_crc != e.computed_crc)
            report_mismatch("computed_crc", result_ch.computed_crc, e.computed_crc);
        if (result_ch.count_field != e.count_field)
            report_mismatch("count_field", result_ch.count_field, e.count_field);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (data_ch.valid && data_ch.ready)
            begin
                mon_item = '{data_ch.data_byte, data_ch.expected_length, data_ch.last_byte};
                absorb_byte(mon_item, mon_done, mon_pred);
                if (mon_done)
                begin
                    mon_want = mon_pred;
                    if (typed_results.size() != 0)
                    begin
                        mon_typed = typed_results.pop_front();
                        if (mon_typed.typed)
                            mon_want = mon_typed.result;
                    end
                    pending_results.push_back(mon_want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("crc16_block_checker verification failed");
            $finish;
        end
    end

    // result side: random stretches of free flow or of random stalls, stall stretches more often
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = ($urandom_range(0, 2) != 0);
            mode_left  = $urandom_range(50, 400);
        end
        else
            mode_left--;
        if (stall_left != 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (stall_mode && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    task automatic push_byte(input logic [7:0] b, input logic [7:0] len, input logic last);
        int gap;
        data_ch.valid           <= 1'b1;
        data_ch.data_byte       <= b;
        data_ch.expected_length <= len;
        data_ch.last_byte       <= last;
        @(posedge clk);
        while (!data_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                data_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic build_block(input logic [7:0] count, input int n, input bit rand_fill,
                               input logic [7:0] fill, input bit add_crc,
                               input logic [15:0] flip);
        logic [15:0] c;
        block_bytes.delete();
        block_bytes.push_back(count);
        for (int i = 1; i < n; i++)
            block_bytes.push_back(rand_fill ? 8'($urandom_range(0, 255)) : fill);
        if (add_crc && n >= 3)
        begin
            c = '0;
            for (int i = 0; i < n - 2; i++)
                c = crc16_lsb_in(c, block_bytes[i]);
            block_bytes[n-2] = c[7:0] ^ flip[7:0];
            block_bytes[n-1] = c[15:8] ^ flip[15:8];
        end
    endtask

    task automatic send_block(input logic [7:0] want, input bit typed, input out_item_t result);
        int n;
        n = block_bytes.size();
        typed_results.push_back('{typed, result});
        for (int i = 0; i < n; i++)
            push_byte(block_bytes[i], (i == 0) ? want : 8'($urandom_range(0, 255)),
                      (i == n - 1));
        blocks_sent++;
        if (n > 255)
            overlong_blocks++;
    endtask

    task automatic drain_results();
        data_ch.valid <= 1'b0;
        while (pending_results.size() != 0 || typed_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_block();
        int          kind;
        int          n;
        int          len;
        logic [7:0]  count;
        logic [7:0]  want;
        bit          add;
        logic [15:0] flip;
        out_item_t   none;
        none = '{STATUS_OK, 16'h0000, 8'h00};
        kind = $urandom_range(0, 99);
        add  = 1'b1;
        flip = '0;
        if (kind < 2)
        begin
            n     = $urandom_range(256, 300);
            count = 8'hFF;
            want  = 8'hFF;
        end
        else if (kind < 4)
        begin
            n     = 255;
            count = 8'hFF;
            want  = 8'hFF;
        end
        else if (kind < 65)
        begin
            n     = $urandom_range(4, 24);
            count = 8'(n);
            want  = count;
            if (kind >= 55)
                flip = 16'($urandom_range(1, 65535));
        end
        else if (kind < 72)
        begin
            n     = $urandom_range(1, 12);
            count = 8'($urandom_range(0, 255));
            want  = count ^ 8'($urandom_range(1, 255));
        end
        else if (kind < 78)
        begin
            count = 8'($urandom_range(0, 3));
            want  = count;
            n     = $urandom_range(1, 6);
        end
        else if (kind < 88)
        begin
            len   = $urandom_range(4, 20);
            n     = ($urandom_range(0, 1) == 0) ? len - $urandom_range(1, 3)
                                                : len + $urandom_range(1, 3);
            count = 8'(len);
            want  = count;
        end
        else
        begin
            n     = $urandom_range(1, 10);
            count = 8'($urandom_range(0, 255));
            want  = ($urandom_range(0, 1) == 0) ? count : 8'($urandom_range(0, 255));
            add   = 1'b0;
        end
        build_block(count, n, 1'b1, 8'h00, add, flip);
        send_block(want, 1'b0, none);
    endtask

    initial
    begin
        bit paused;
        rst_n                   = 1'b0;
        data_ch.valid           = 1'b0;
        data_ch.data_byte       = '0;
        data_ch.expected_length = '0;
        data_ch.last_byte       = 1'b0;
        result_ch.ready         = 1'b0;
        mismatches              = 0;
        results_checked         = 0;
        items_sent              = 0;
        blocks_sent             = 0;
        overlong_blocks         = 0;
        cycle_count             = 0;
        burst_left              = 0;
        stall_left              = 0;
        mode_left               = 0;
        paused                  = 1'b0;
        foreach (status_hits[i])
            status_hits[i] = 0;
        clear_block_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_blocks[r])
        begin
            build_block(dir_blocks[r].count, dir_blocks[r].nbytes, 1'b0, dir_blocks[r].fill,
                        dir_blocks[r].add_crc, dir_blocks[r].crc_flip);
            send_block(dir_blocks[r].want, dir_blocks[r].typed, dir_blocks[r].result);
        end
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_BYTES)
        begin
            random_block();
            if (!paused && items_sent >= RANDOM_BYTES / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end

        drain_results();
        $display("Covered %0d blocks (%0d overlong), %0d results checked, %0d mismatches",
                 blocks_sent, overlong_blocks, results_checked, mismatches);
        $display("Status mix: ok %0d, count %0d, short %0d, total %0d, crc %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (mismatches == 0)
            $display("crc16_block_checker verification clean");
        else
            $display("crc16_block_checker verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/crc16bc_pkg.sv
rtl/crc16bc_if.sv
rtl/crc16bc_in_stage.sv
rtl/crc16bc_core.sv
rtl/crc16_block_checker.sv
rtl/crc16bc_checker.sv
dv/crc16_block_checker_tb.sv
